FILE: design/pcm_sample_voice_player_unit_assert.svh
// assertion helpers used by the voice player back end (psvp_back)
`ifndef PCM_SAMPLE_VOICE_PLAYER_UNIT_ASSERT_SVH
`define PCM_SAMPLE_VOICE_PLAYER_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define PSVP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PSVP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/psvp_pkg.sv
`default_nettype none

package psvp_pkg;

    localparam int SAMPLE_WORDS   = 65536;
    localparam int ADDR_W         = $clog2(SAMPLE_WORDS);
    localparam int RATE_FRAC_BITS = 16;

    localparam int RATE_W  = 20;
    localparam int GAIN_W  = 16;
    localparam int FC_W    = 17;
    localparam int FRAME_W = 48;
    localparam int SMP_W   = 16;
    localparam int MIX_W   = 24;
    localparam int POS_W   = FC_W + RATE_FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // gain q4.12 times sample q1.15 gives 27 fraction bits, mix has 23
    localparam int PROD_W = GAIN_W + SMP_W;
    localparam int SCL_SH = 4;
    localparam int SCL_W  = PROD_W - SCL_SH;
    localparam int SUM_W  = SCL_W + 1;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCHED = 2'd1;
    localparam logic [1:0] ST_PLAY  = 2'd2;
    localparam logic [1:0] ST_STOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_SRC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_OUT = 3'd4;

    typedef struct packed {
        logic [RATE_W-1:0]        rate;
        logic signed [GAIN_W-1:0] gain;
        logic [FC_W-1:0]          num_frames;
        logic                     stereo_src;
        logic                     stereo_out;
    } t_cfg;

    typedef struct packed {
        logic                    is_tick;
        logic                    wr_en;
        logic [ADDR_W-1:0]       wr_addr;
        logic signed [SMP_W-1:0] wr_data;
        logic [ADDR_W-1:0]       rd_addr_l;
        logic [ADDR_W-1:0]       rd_addr_r;
        logic                    use_l;
        logic                    use_r;
        logic signed [MIX_W-1:0] mix_l;
        logic signed [MIX_W-1:0] mix_r;
        logic [1:0]              status;
    } t_cmd;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix_l;
        logic signed [MIX_W-1:0] mix_r;
        logic [1:0]              status;
    } t_res;

endpackage

`default_nettype wire

FILE: design/pcm_sample_voice_player_unit.sv
// path: command queue, sample read register, gain multiply register, output queue
// throughput: one transaction per cycle while the command queue has room and the
//   output queue has credit, set by one sample memory access and one multiply per channel
// reset: voice state, queues and config registers return to defaults;
//   sample memory keeps its contents and is undefined until written
`default_nettype none

module pcm_sample_voice_player_unit
    import psvp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_opcode,
    input  logic [FRAME_W-1:0]        i_engine_frame,
    input  logic [FRAME_W-1:0]        i_start_frame,
    input  logic [15:0]               i_sample_address,
    input  logic signed [SMP_W-1:0]   i_sample_value,
    input  logic signed [MIX_W-1:0]   i_mix_in_left,
    input  logic signed [MIX_W-1:0]   i_mix_in_right,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [MIX_W-1:0]   o_mix_out_left,
    output logic signed [MIX_W-1:0]   o_mix_out_right,
    output logic [1:0]                o_voice_status,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]     i_cfg_wdata
);

    t_cfg r_cfg;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_head;
    logic w_q_pop;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate        <= RATE_W'(1 << RATE_FRAC_BITS);
            r_cfg.gain        <= GAIN_W'(4096);
            r_cfg.num_frames  <= FC_W'(1);
            r_cfg.stereo_src  <= 1'b0;
            r_cfg.stereo_out  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_RATE:       r_cfg.rate        <= i_cfg_wdata[RATE_W-1:0];
                CFG_GAIN:       r_cfg.gain        <= i_cfg_wdata[GAIN_W-1:0];
                CFG_FRAME_CNT:  r_cfg.num_frames  <= i_cfg_wdata[FC_W-1:0];
                CFG_STEREO_SRC: r_cfg.stereo_src  <= i_cfg_wdata[0];
                CFG_STEREO_OUT: r_cfg.stereo_out  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    psvp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_q_full         (w_q_full),
        .i_opcode         (i_opcode),
        .i_engine_frame   (i_engine_frame),
        .i_start_frame    (i_start_frame),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_mix_in_left    (i_mix_in_left),
        .i_mix_in_right   (i_mix_in_right),
        .i_cfg            (r_cfg),
        .o_cmd_valid      (w_cmd_valid),
        .o_cmd            (w_cmd)
    );

    psvp_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  (w_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .i_pop   (w_q_pop)
    );

    psvp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_head),
        .o_cmd_pop   (w_q_pop),
        .i_gain      (r_cfg.gain),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    assign full            = w_q_full;
    assign o_mix_out_left  = w_res.mix_l;
    assign o_mix_out_right = w_res.mix_r;
    assign o_voice_status  = w_res.status;

endmodule

`default_nettype wire

FILE: design/psvp_front.sv
`default_nettype none

module psvp_front
    import psvp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_q_full,
    input  logic [1:0]                i_opcode,
    input  logic [FRAME_W-1:0]        i_engine_frame,
    input  logic [FRAME_W-1:0]        i_start_frame,
    input  logic [15:0]               i_sample_address,
    input  logic signed [SMP_W-1:0]   i_sample_value,
    input  logic signed [MIX_W-1:0]   i_mix_in_left,
    input  logic signed [MIX_W-1:0]   i_mix_in_right,
    input  t_cfg                      i_cfg,
    output logic                      o_cmd_valid,
    output t_cmd                      o_cmd
);

    logic [1:0]         r_state, n_state;
    logic [FRAME_W-1:0] r_pending, n_pending;
    logic [POS_W-1:0]   r_pos, n_pos;

    logic               w_accept;
    logic [1:0]         w_eff_state;
    logic               w_mixing;
    logic [FC_W-1:0]    w_src;
    logic [POS_W:0]     w_pos_adv;
    logic [POS_W:0]     w_pos_end;
    logic [FC_W:0]      w_base_l;
    logic [FC_W:0]      w_base_r;
    logic               w_l_ok;
    logic               w_r_ok;
    logic               w_ld_ok;

    assign w_accept  = i_push && !i_q_full;
    assign w_src     = r_pos[POS_W-1:RATE_FRAC_BITS];
    // one spare bit so a step past the last frame does not wrap
    assign w_pos_adv = {1'b0, r_pos} + (POS_W+1)'(i_cfg.rate);
    assign w_pos_end = {1'b0, i_cfg.num_frames, RATE_FRAC_BITS'(0)};

    // interleaved stereo source: left at word 2*i, right at word 2*i+1; mono reads word i for both
    assign w_base_l = i_cfg.stereo_src ? {w_src, 1'b0} : {1'b0, w_src};
    assign w_base_r = i_cfg.stereo_src ? w_base_l + (FC_W+1)'(1) : w_base_l;
    assign w_l_ok   = 32'(w_base_l) < 32'(SAMPLE_WORDS);
    assign w_r_ok   = 32'(w_base_r) < 32'(SAMPLE_WORDS);
    assign w_ld_ok  = 32'(i_sample_address) < 32'(SAMPLE_WORDS);

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_pos       = r_pos;
        w_mixing    = 1'b0;
        w_eff_state = r_state;
        if (r_state == ST_SCHED && r_pending <= i_engine_frame) begin
            w_eff_state = ST_PLAY;
        end
        unique case (i_opcode)
            OP_START: begin
                n_pos = '0;
                if (i_start_frame < i_engine_frame) begin
                    n_pending = i_engine_frame;
                    n_state   = ST_PLAY;
                end else begin
                    n_pending = i_start_frame;
                    n_state   = ST_SCHED;
                end
            end
            OP_STOP: begin
                n_state = ST_STOP;
            end
            OP_TICK: begin
                n_state = w_eff_state;
                if (w_eff_state == ST_STOP) begin
                    n_state = ST_IDLE;
                end else if (w_eff_state == ST_PLAY) begin
                    if (w_src >= i_cfg.num_frames) begin
                        n_state = ST_IDLE;
                    end else begin
                        w_mixing = 1'b1;
                        n_pos    = w_pos_adv[POS_W-1:0];
                        if (w_pos_adv >= w_pos_end) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd.is_tick   = (i_opcode == OP_TICK);
        o_cmd.wr_en     = (i_opcode == OP_LOAD) && w_ld_ok;
        o_cmd.wr_addr   = ADDR_W'(i_sample_address);
        o_cmd.wr_data   = i_sample_value;
        o_cmd.rd_addr_l = ADDR_W'(w_base_l);
        o_cmd.rd_addr_r = ADDR_W'(w_base_r);
        // out-of-range reads contribute nothing
        o_cmd.use_l     = w_mixing && w_l_ok;
        o_cmd.use_r     = w_mixing && i_cfg.stereo_out && w_r_ok;
        o_cmd.mix_l     = i_mix_in_left;
        o_cmd.mix_r     = i_mix_in_right;
        o_cmd.status    = n_state;
    end

    assign o_cmd_valid = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= '0;
            r_pos     <= '0;
        end else if (w_accept) begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_pos     <= n_pos;
        end
    end

endmodule

`default_nettype wire

FILE: design/psvp_cmd_queue.sv
`default_nettype none

module psvp_cmd_queue
    import psvp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wptr;
    logic [CQ_PTR_W-1:0] r_rptr;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic                w_wr;
    logic                w_rd;

    assign o_full  = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + CQ_PTR_W'(1);
            end
            if (w_rd) begin
                r_rptr <= r_rptr + CQ_PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CQ_CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/psvp_back.sv
`default_nettype none

`include "pcm_sample_voice_player_unit_assert.svh"

module psvp_back
    import psvp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_cmd_pop,
    input  logic signed [GAIN_W-1:0] i_gain,
    input  logic                     i_pop,
    output logic                     o_empty,
    output t_res                     o_res
);

    typedef struct packed {
        logic                    is_tick;
        logic                    use_l;
        logic                    use_r;
        logic signed [MIX_W-1:0] mix_l;
        logic signed [MIX_W-1:0] mix_r;
        logic [1:0]              status;
    } t_meta;

    localparam logic signed [PROD_W-1:0] RND     = PROD_W'(1 << (SCL_SH - 1));
    localparam logic signed [SUM_W-1:0]  MIX_MAX = SUM_W'((1 << (MIX_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  MIX_MIN = -SUM_W'(1 << (MIX_W - 1));

    function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > MIX_MAX) begin
            c = MIX_MAX;
        end else if (v < MIX_MIN) begin
            c = MIX_MIN;
        end
        return c[MIX_W-1:0];
    endfunction

    logic signed [SMP_W-1:0]  r_mem [SAMPLE_WORDS];
    logic signed [SMP_W-1:0]  r_rd_l;
    logic signed [SMP_W-1:0]  r_rd_r;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    t_meta                    r_m1;
    t_meta                    r_m2;
    logic                     r_v1;
    logic                     r_v2;

    t_res                     r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]      r_oq_wp;
    logic [OQ_PTR_W-1:0]      r_oq_rp;
    logic [OQ_CNT_W-1:0]      r_oq_cnt;

    logic [OQ_CNT_W:0]        w_used;
    logic                     w_issue;
    logic signed [PROD_W-1:0] w_rnd_l;
    logic signed [PROD_W-1:0] w_rnd_r;
    logic signed [SCL_W-1:0]  w_add_l;
    logic signed [SCL_W-1:0]  w_add_r;
    logic signed [SUM_W-1:0]  w_sum_l;
    logic signed [SUM_W-1:0]  w_sum_r;
    t_res                     w_res;
    logic                     w_oq_wr;
    logic                     w_oq_rd;

    // issue only when the output queue has room for everything in flight
    assign w_used = {1'b0, r_oq_cnt} + (OQ_CNT_W+1)'(r_v1) + (OQ_CNT_W+1)'(r_v2);
    assign w_issue   = i_cmd_valid && (w_used < (OQ_CNT_W+1)'(OQ_DEPTH));
    assign o_cmd_pop = w_issue;

    // stage 1: sample memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_issue && i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (w_issue && i_cmd.is_tick) begin
            r_rd_l <= r_mem[i_cmd.rd_addr_l];
            r_rd_r <= r_mem[i_cmd.rd_addr_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_m1.is_tick <= i_cmd.is_tick;
            r_m1.use_l   <= i_cmd.use_l;
            r_m1.use_r   <= i_cmd.use_r;
            r_m1.mix_l   <= i_cmd.mix_l;
            r_m1.mix_r   <= i_cmd.mix_r;
            r_m1.status  <= i_cmd.status;
        end
        // stage 2: gain multiply
        r_m2     <= r_m1;
        r_prod_l <= i_gain * r_rd_l;
        r_prod_r <= i_gain * r_rd_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    // stage 3: round to q1.23, add into the mix, saturate; non-tick results carry a zero mix
    always_comb begin
        w_rnd_l = r_prod_l + RND;
        w_rnd_r = r_prod_r + RND;
        w_add_l = r_m2.use_l ? w_rnd_l[PROD_W-1:SCL_SH] : '0;
        w_add_r = r_m2.use_r ? w_rnd_r[PROD_W-1:SCL_SH] : '0;
        w_sum_l = r_m2.mix_l + w_add_l;
        w_sum_r = r_m2.mix_r + w_add_r;
        w_res.status = r_m2.status;
        if (r_m2.is_tick) begin
            w_res.mix_l = sat_mix(w_sum_l);
            w_res.mix_r = sat_mix(w_sum_r);
        end else begin
            w_res.mix_l = '0;
            w_res.mix_r = '0;
        end
    end

    assign w_oq_wr = r_v2;
    assign w_oq_rd = i_pop && !o_empty;
    assign o_empty = (r_oq_cnt == '0);
    assign o_res   = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (w_oq_wr) begin
            r_oq[r_oq_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (w_oq_wr) begin
                r_oq_wp <= r_oq_wp + OQ_PTR_W'(1);
            end
            if (w_oq_rd) begin
                r_oq_rp <= r_oq_rp + OQ_PTR_W'(1);
            end
            if (w_oq_wr && !w_oq_rd) begin
                r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(1);
            end else if (w_oq_rd && !w_oq_wr) begin
                r_oq_cnt <= r_oq_cnt - OQ_CNT_W'(1);
            end
        end
    end

    `PSVP_ASSERT_ALWAYS(a_oq_credit, i_clk, i_rst_n, w_used <= (OQ_CNT_W+1)'(OQ_DEPTH), "output queue credit exceeded")
    `PSVP_ASSERT_IMPLY(a_oq_no_overflow, i_clk, i_rst_n, w_oq_wr, r_oq_cnt < OQ_CNT_W'(OQ_DEPTH), "result written into full output queue")
    `PSVP_ASSERT_IMPLY(a_stage_order, i_clk, i_rst_n, r_v2, $past(r_v1), "multiply stage valid without read stage")

endmodule

`default_nettype wire
